/* rtl/ksel_pkg.sv */
// Shared types, constants and codes for the k-smallest selector.
`timescale 1ns / 1ps
`default_nettype none

package ksel_pkg;

   localparam int CAPACITY_DEF = 32;
   localparam int DATA_W       = 64;
   localparam int CSR_W        = 6;

   localparam logic [CSR_W-1:0] KEEP_RESET = 6'd32;

   localparam logic OP_OFFER = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   typedef struct packed {
      logic                     opcode;
      logic signed [DATA_W-1:0] sample_value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] kept_value;
      logic                     last_flag;
      logic                     empty_flag;
   } rsp_type;

   // Per-cycle command broadcast to every cell of the sorted row.
   typedef struct packed {
      logic insert;
      logic shift;
   } cell_ctrl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DRAIN,
      ST_EMPTY
   } state_type;

endpackage

`default_nettype wire

/* rtl/ksel_cell.sv */
// One cell of the sorted row: holds one kept value and trades with its neighbors.
`timescale 1ns / 1ps
`default_nettype none

module ksel_cell (
   input  wire logic                              clock,
   input  wire ksel_pkg::cell_ctrl_type           ctrl,
   input  wire logic signed [ksel_pkg::DATA_W-1:0] key,
   input  wire logic signed [ksel_pkg::DATA_W-1:0] left_value,
   input  wire logic                              left_lt,
   input  wire logic signed [ksel_pkg::DATA_W-1:0] right_value,
   input  wire logic                              cell_valid,
   output logic signed [ksel_pkg::DATA_W-1:0]      value,
   output logic                                   lt
);
   import ksel_pkg::*;

   logic signed [DATA_W-1:0] value_ff;
   logic signed [DATA_W-1:0] value_in;

   // An empty cell counts as larger than any key, so the valid prefix stays sorted.
   assign lt    = !cell_valid || (key < value_ff);
   assign value = value_ff;

   always_comb begin
      value_in = value_ff;
      if (ctrl.insert && lt) begin
         // The key lands in the first cell it beats; cells after it shift right.
         value_in = left_lt ? left_value : key;
      end else if (ctrl.shift) begin
         value_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

`default_nettype wire

/* rtl/streaming_k_smallest_selector.sv */
// Top level of the streaming k-smallest selector built on a sorted row of cells.
//
// Usage: items arrive on the req_ channel (valid/stall). An offer item
// (opcode 0) carries a signed 64-bit sample; the block keeps the keep_count
// smallest samples seen so far, sorted ascending in a row of CAPACITY cells.
// An offer is absorbed without a stall and produces no result. A drain item
// (opcode 1) emits every kept value in ascending order on the rsp_ channel,
// the final one with last_flag set, and empties the row; a drain of an empty
// row emits one result with empty_flag and last_flag set and a zero value.
// Offers can follow back to back; a drain shifts one cell per result and
// keeps req_stall high until its last result. The first drain result passes
// the state register, then the output register, before it shows on rsp_.
// keep_count is written through the csr_ port, which is always ready; it
// must be written only between streams, which the block does not enforce.
// At reset the row is empty, keep_count is 32 and no result is pending.
// A receiver stall holds the output register and pauses a drain in progress.
`timescale 1ns / 1ps
`default_nettype none

module streaming_k_smallest_selector #(
   parameter int CAPACITY = ksel_pkg::CAPACITY_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire ksel_pkg::req_type              req_data,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output ksel_pkg::rsp_type                   rsp_data,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [ksel_pkg::CSR_W-1:0]     csr_data
);
   import ksel_pkg::*;

   // Count of held values needs to reach CAPACITY itself.
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CMP_W = CNT_W + CSR_W;

   state_type                state_ff, state_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CSR_W-1:0]         keep_ff,  keep_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_data_ff,  rsp_data_in;

   cell_ctrl_type            cell_ctrl;
   logic signed [DATA_W-1:0] value_w [CAPACITY];
   logic [CAPACITY-1:0]      lt_w;
   logic [CAPACITY-1:0]      valid_w;

   logic [CNT_W-1:0]         limit;
   logic [CMP_W-1:0]         keep_ext;
   logic [CNT_W-1:0]         count_m1;
   logic                     req_accept;
   logic                     slot_free;
   logic                     beats_max;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign slot_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // Effective limit: keep_count clamped into 1..CAPACITY.
   assign keep_ext = CMP_W'(keep_ff);
   always_comb begin
      if (keep_ff == '0) begin
         limit = CNT_W'(1);
      end else if (keep_ext > CMP_W'(CAPACITY)) begin
         limit = CNT_W'(CAPACITY);
      end else begin
         limit = keep_ext[CNT_W-1:0];
      end
   end

   // The largest kept value sits in cell count-1; its compare bit says whether
   // a new sample would replace it once the row is full.
   assign count_m1  = count_ff - CNT_W'(1);
   assign beats_max = (count_ff != '0) && lt_w[count_m1[IDX_W-1:0]];

   // The row of cells. Cell 0 has no left neighbor, so a key that beats it
   // always lands there; the last cell refills itself on a shift.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      assign valid_w[i] = (CNT_W'(i) < count_ff);
      if (i == 0) begin : g_first
         if (CAPACITY == 1) begin : g_only
            ksel_cell u_cell (
               .clock       (clock),
               .ctrl        (cell_ctrl),
               .key         (req_data.sample_value),
               .left_value  (req_data.sample_value),
               .left_lt     (1'b0),
               .right_value (value_w[i]),
               .cell_valid  (valid_w[i]),
               .value       (value_w[i]),
               .lt          (lt_w[i])
            );
         end else begin : g_head
            ksel_cell u_cell (
               .clock       (clock),
               .ctrl        (cell_ctrl),
               .key         (req_data.sample_value),
               .left_value  (req_data.sample_value),
               .left_lt     (1'b0),
               .right_value (value_w[i+1]),
               .cell_valid  (valid_w[i]),
               .value       (value_w[i]),
               .lt          (lt_w[i])
            );
         end
      end else if (i == CAPACITY - 1) begin : g_last
         ksel_cell u_cell (
            .clock       (clock),
            .ctrl        (cell_ctrl),
            .key         (req_data.sample_value),
            .left_value  (value_w[i-1]),
            .left_lt     (lt_w[i-1]),
            .right_value (value_w[i]),
            .cell_valid  (valid_w[i]),
            .value       (value_w[i]),
            .lt          (lt_w[i])
         );
      end else begin : g_mid
         ksel_cell u_cell (
            .clock       (clock),
            .ctrl        (cell_ctrl),
            .key         (req_data.sample_value),
            .left_value  (value_w[i-1]),
            .left_lt     (lt_w[i-1]),
            .right_value (value_w[i+1]),
            .cell_valid  (valid_w[i]),
            .value       (value_w[i]),
            .lt          (lt_w[i])
         );
      end
   end

   // Sequencer: offers in idle, then one result per free output slot on drain.
   always_comb begin
      state_in         = state_ff;
      count_in         = count_ff;
      keep_in          = keep_ff;
      cell_ctrl.insert = 1'b0;
      cell_ctrl.shift  = 1'b0;
      rsp_data_in      = rsp_data_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;

      if (csr_valid && csr_ready) begin
         keep_in = csr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_data.opcode == OP_DRAIN) begin
                  state_in = (count_ff == '0) ? ST_EMPTY : ST_DRAIN;
               end else if (count_ff < limit) begin
                  // Still filling: insert and grow.
                  cell_ctrl.insert = 1'b1;
                  count_in         = count_ff + CNT_W'(1);
               end else if (beats_max) begin
                  // Full: insert, the largest falls out past count-1.
                  cell_ctrl.insert = 1'b1;
               end
            end
         end
         ST_DRAIN: begin
            if (slot_free) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.kept_value = value_w[0];
               rsp_data_in.last_flag  = (count_ff == CNT_W'(1));
               rsp_data_in.empty_flag = 1'b0;
               cell_ctrl.shift        = 1'b1;
               count_in               = count_m1;
               if (count_ff == CNT_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_EMPTY: begin
            if (slot_free) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.kept_value = '0;
               rsp_data_in.last_flag  = 1'b1;
               rsp_data_in.empty_flag = 1'b1;
               state_in               = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         keep_ff      <= KEEP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         keep_ff      <= keep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

/* rtl/ksel_checker.sv */
// Port-level assertions for the k-smallest selector, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module ksel_checker (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_valid,
   input wire logic                       req_stall,
   input wire ksel_pkg::req_type          req_data,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_stall,
   input wire ksel_pkg::rsp_type          rsp_data
);
   import ksel_pkg::*;

   // A result waiting on a stalled receiver stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // An empty-drain result is the only one of its run and carries zero.
   a_empty_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.empty_flag |-> rsp_data.last_flag && (rsp_data.kept_value == '0))
      else $error("malformed empty result");

   // Once a drain item is taken the block holds off new items while it emits.
   a_drain_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_data.opcode == OP_DRAIN) |=> req_stall)
      else $error("input not held off during drain");

   // Reset leaves no result pending.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A drain result can only appear while the block is busy draining or just after.
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result without a drain in progress");

endmodule

bind streaming_k_smallest_selector ksel_checker u_ksel_checker (.*);

`default_nettype wire
